### design/h2r_pkg.sv
// h2r_pkg: shared types and constants (Q1.16 levels, Q0.16 hue) for the HSL to RGB converter.
// No dependencies.
`default_nettype none

package h2r_pkg;

  localparam int HUE_W  = 16;
  localparam int VAL_W  = 17;
  localparam int PROD_W = 2 * VAL_W;
  localparam int FRAC_W = 16;
  localparam int IDX_W  = 1;

  localparam logic [VAL_W-1:0] FX_ONE        = 17'd65536;
  localparam logic [VAL_W-1:0] FX_HALF       = 17'd32768;
  localparam logic [HUE_W-1:0] FX_SIXTH      = 16'd10922;
  localparam logic [HUE_W-1:0] FX_HUE_HALF   = 16'd32768;
  localparam logic [HUE_W-1:0] FX_THIRD      = 16'd21845;
  localparam logic [HUE_W-1:0] FX_TWO_THIRDS = 16'd43690;

  localparam logic [VAL_W-1:0] SAT_RESET   = 17'd45875;
  localparam logic [VAL_W-1:0] LIGHT_RESET = 17'd13107;

  localparam logic [IDX_W-1:0] REG_SATURATION = 1'd0;
  localparam logic [IDX_W-1:0] REG_LIGHTNESS  = 1'd1;

  typedef enum logic [1:0] {
    RGN_RISE,
    RGN_HIGH,
    RGN_FALL,
    RGN_LOW
  } region_t;

  typedef struct packed {
    region_t          region;
    logic [VAL_W-1:0] factor;
  } chan_ctl_t;

  typedef struct packed {
    logic [VAL_W-1:0] p;
    logic [VAL_W-1:0] q;
    logic [VAL_W-1:0] d;
  } level_t;

endpackage

`default_nettype wire

### design/h2r_regions.sv
// h2r_regions: first stage, per-channel hue offset, region and slope factor.
// Depends on h2r_pkg.
`default_nettype none

module h2r_regions
  import h2r_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             adv,
  input  wire logic [HUE_W-1:0] hue,
  output chan_ctl_t             red_ctl_r,
  output chan_ctl_t             green_ctl_r,
  output chan_ctl_t             blue_ctl_r
);

  function automatic chan_ctl_t classify(input logic [HUE_W-1:0] t);
    chan_ctl_t        c;
    logic [VAL_W-1:0] t17;
    logic [VAL_W-1:0] u;
    t17 = {1'b0, t};
    u   = {1'b0, FX_TWO_THIRDS} - t17;
    if (t < FX_SIXTH) begin
      c.region = RGN_RISE;
      c.factor = (t17 << 2) + (t17 << 1);
    end else if (t < FX_HUE_HALF) begin
      c.region = RGN_HIGH;
      c.factor = '0;
    end else if (t < FX_TWO_THIRDS) begin
      c.region = RGN_FALL;
      c.factor = (u << 2) + (u << 1);
    end else begin
      c.region = RGN_LOW;
      c.factor = '0;
    end
    return c;
  endfunction

  chan_ctl_t red_ctl_nxt, green_ctl_nxt, blue_ctl_nxt;

  always_comb begin
    red_ctl_nxt   = classify(hue + FX_THIRD);
    green_ctl_nxt = classify(hue);
    blue_ctl_nxt  = classify(hue - FX_THIRD);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      red_ctl_r   <= red_ctl_nxt;
      green_ctl_r <= green_ctl_nxt;
      blue_ctl_r  <= blue_ctl_nxt;
    end
  end

endmodule

`default_nettype wire

### design/h2r_levels.sv
// h2r_levels: two stages deriving the low level p, high level q and span q-p
// from saturation and lightness. Depends on h2r_pkg.
`default_nettype none

module h2r_levels
  import h2r_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             adv,
  input  wire logic [VAL_W-1:0] saturation,
  input  wire logic [VAL_W-1:0] lightness,
  output level_t                level_r
);

  logic [VAL_W-1:0]  s_a_r, l_a_r;
  logic [PROD_W-1:0] ls_a_r;
  logic [VAL_W-1:0]  s_sat, l_sat;
  logic [VAL_W-1:0]  m;
  logic [VAL_W:0]    q_wide, p_wide;
  level_t            level_nxt;

  always_comb begin
    s_sat = (saturation > FX_ONE) ? FX_ONE : saturation;
    l_sat = (lightness > FX_ONE) ? FX_ONE : lightness;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_a_r  <= s_sat;
      l_a_r  <= l_sat;
      ls_a_r <= l_sat * s_sat;
    end
  end

  always_comb begin
    m = ls_a_r[FRAC_W +: VAL_W];
    if (l_a_r < FX_HALF) begin
      q_wide = {1'b0, l_a_r} + {1'b0, m};
    end else begin
      q_wide = {1'b0, l_a_r} + {1'b0, s_a_r} - {1'b0, m};
    end
    p_wide      = {l_a_r, 1'b0} - q_wide;
    level_nxt.q = q_wide[VAL_W-1:0];
    level_nxt.p = p_wide[VAL_W-1:0];
    level_nxt.d = q_wide[VAL_W-1:0] - p_wide[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      level_r <= level_nxt;
    end
  end

endmodule

`default_nettype wire

### design/h2r_channel.sv
// h2r_channel: last two stages of one color channel, slope multiply then
// region select and clamp into the output register. Depends on h2r_pkg.
`default_nettype none

module h2r_channel
  import h2r_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             adv,
  input  wire chan_ctl_t        ctl,
  input  wire level_t           level,
  output logic      [VAL_W-1:0] value_r
);

  logic [PROD_W-1:0] prod_r;
  region_t           region_r;
  logic [VAL_W-1:0]  p_r, q_r;
  logic [VAL_W:0]    scaled;
  logic [VAL_W+1:0]  sum;
  logic [VAL_W+1:0]  sel;
  logic [VAL_W-1:0]  value_nxt;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r   <= level.d * ctl.factor;
      region_r <= ctl.region;
      p_r      <= level.p;
      q_r      <= level.q;
    end
  end

  always_comb begin
    scaled = prod_r[FRAC_W +: VAL_W+1];
    sum    = {2'b00, p_r} + {1'b0, scaled};
    case (region_r) inside
      RGN_RISE, RGN_FALL: sel = sum;
      RGN_HIGH:           sel = {2'b00, q_r};
      default:            sel = {2'b00, p_r};
    endcase
    value_nxt = (sel > {2'b00, FX_ONE}) ? FX_ONE : sel[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      value_r <= value_nxt;
    end
  end

endmodule

`default_nettype wire

### design/hsl_to_rgb_converter_unit.sv
// hsl_to_rgb_converter_unit: top level, config registers, valid pipeline.
// Depends on h2r_pkg, h2r_regions, h2r_levels, h2r_channel.
//
//  channel  direction  handshake            payload
//  in       sink       in_valid/in_stall    in_hue[15:0]
//  out      source     out_valid/out_stall  out_red, out_green, out_blue [16:0]
//  cfg      sink       cfg_wr_en            cfg_index[0:0], cfg_wdata[16:0]
//
// One hue per cycle unless a stalled result holds the pipeline; each result
// passes through the four register stages: hue classify / l*s multiply,
// level add, slope multiply, select and clamp.
// Reset clears the stage valid bits and loads the register reset values.
// out_stall with a waiting result freezes every stage and raises in_stall.
`default_nettype none

module hsl_to_rgb_converter_unit
  import h2r_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [HUE_W-1:0] in_hue,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [VAL_W-1:0] out_red,
  output logic      [VAL_W-1:0] out_green,
  output logic      [VAL_W-1:0] out_blue,
  input  wire logic             cfg_wr_en,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [VAL_W-1:0] cfg_wdata
);

  logic [VAL_W-1:0] saturation_r, lightness_r;
  logic             v_a_r, v_b_r, v_c_r, v_out_r;
  logic             adv;
  chan_ctl_t        red_a, green_a, blue_a;
  chan_ctl_t        red_b_r, green_b_r, blue_b_r;
  level_t           level_b;

  assign adv       = !v_out_r || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = v_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      saturation_r <= SAT_RESET;
      lightness_r  <= LIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SATURATION: saturation_r <= cfg_wdata;
        REG_LIGHTNESS:  lightness_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r   <= 1'b0;
      v_b_r   <= 1'b0;
      v_c_r   <= 1'b0;
      v_out_r <= 1'b0;
    end else if (adv) begin
      v_a_r   <= in_valid;
      v_b_r   <= v_a_r;
      v_c_r   <= v_b_r;
      v_out_r <= v_c_r;
    end
  end

  h2r_regions u_regions (
    .clk         (clk),
    .adv         (adv),
    .hue         (in_hue),
    .red_ctl_r   (red_a),
    .green_ctl_r (green_a),
    .blue_ctl_r  (blue_a)
  );

  h2r_levels u_levels (
    .clk        (clk),
    .adv        (adv),
    .saturation (saturation_r),
    .lightness  (lightness_r),
    .level_r    (level_b)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      red_b_r   <= red_a;
      green_b_r <= green_a;
      blue_b_r  <= blue_a;
    end
  end

  h2r_channel u_red (
    .clk     (clk),
    .adv     (adv),
    .ctl     (red_b_r),
    .level   (level_b),
    .value_r (out_red)
  );

  h2r_channel u_green (
    .clk     (clk),
    .adv     (adv),
    .ctl     (green_b_r),
    .level   (level_b),
    .value_r (out_green)
  );

  h2r_channel u_blue (
    .clk     (clk),
    .adv     (adv),
    .ctl     (blue_b_r),
    .level   (level_b),
    .value_r (out_blue)
  );

`ifndef SYNTHESIS
  a_in_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_a_r)
    else $error("accepted transfer did not enter first stage");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable({v_a_r, v_b_r, v_c_r, v_out_r}) && $stable(out_red))
    else $error("pipeline moved while stalled");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_red <= FX_ONE) && (out_green <= FX_ONE) && (out_blue <= FX_ONE))
    else $error("channel value above one");

  a_level_order: assert property (@(posedge clk) disable iff (!rst_n)
    v_c_r |-> ($past(level_b.p) <= $past(level_b.q)))
    else $error("low level above high level");
`endif

endmodule

`default_nettype wire

### tb/sv/tb_hsl_to_rgb_converter_unit.sv
// Testbench for hsl_to_rgb_converter_unit: directed table, then random hue streams
// under several saturation/lightness settings, checked against a Q1.16 color predictor.
// Depends on h2r_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_hsl_to_rgb_converter_unit;
  import h2r_pkg::*;

  localparam int PIPE_LAT    = 4;
  localparam int HOLD_CYCLES = 64;
  localparam int DIR_N       = 20;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 125;

  typedef struct packed {
    logic [VAL_W-1:0] red;
    logic [VAL_W-1:0] green;
    logic [VAL_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [VAL_W-1:0] sat;
    logic [VAL_W-1:0] light;
    logic [HUE_W-1:0] hue;
    logic             known;
    logic [VAL_W-1:0] red;
    logic [VAL_W-1:0] green;
    logic [VAL_W-1:0] blue;
  } dir_row_t;

  // known rows carry the result typed in; the others go through the predictor
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{17'd45875,  17'd13107,  16'd0,     1'b0, 17'd0,     17'd0,     17'd0},
    '{17'd45875,  17'd13107,  16'd65535, 1'b0, 17'd0,     17'd0,     17'd0},
    '{17'd45875,  17'd13107,  16'd10921, 1'b0, 17'd0,     17'd0,     17'd0},
    '{17'd45875,  17'd13107,  16'd10922, 1'b0, 17'd0,     17'd0,     17'd0},
    '{17'd45875,  17'd13107,  16'd32767, 1'b0, 17'd0,     17'd0,     17'd0},
    '{17'd45875,  17'd13107,  16'd32768, 1'b0, 17'd0,     17'd0,     17'd0},
    '{17'd45875,  17'd13107,  16'd43689, 1'b0, 17'd0,     17'd0,     17'd0},
    '{17'd45875,  17'd13107,  16'd43690, 1'b0, 17'd0,     17'd0,     17'd0},
    '{17'd45875,  17'd13107,  16'd21845, 1'b0, 17'd0,     17'd0,     17'd0},
    '{17'd0,      17'd40000,  16'd12345, 1'b1, 17'd40000, 17'd40000, 17'd40000},
    '{17'd0,      17'd65536,  16'd0,     1'b1, 17'd65536, 17'd65536, 17'd65536},
    '{17'd0,      17'd0,      16'd65535, 1'b1, 17'd0,     17'd0,     17'd0},
    '{17'd65536,  17'd32768,  16'd0,     1'b1, 17'd65536, 17'd0,     17'd0},
    '{17'd131071, 17'd32768,  16'd0,     1'b1, 17'd65536, 17'd0,     17'd0},
    '{17'd131071, 17'd131071, 16'd5000,  1'b1, 17'd65536, 17'd65536, 17'd65536},
    '{17'd65536,  17'd0,      16'd40000, 1'b1, 17'd0,     17'd0,     17'd0},
    '{17'd65537,  17'd100000, 16'd30000, 1'b0, 17'd0,     17'd0,     17'd0},
    '{17'd30000,  17'd50000,  16'd7000,  1'b0, 17'd0,     17'd0,     17'd0},
    '{17'd30000,  17'd32767,  16'd20000, 1'b0, 17'd0,     17'd0,     17'd0},
    '{17'd1,      17'd65535,  16'd65535, 1'b0, 17'd0,     17'd0,     17'd0}
  };

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [HUE_W-1:0] in_hue;
  logic             out_valid;
  logic             out_stall;
  logic [VAL_W-1:0] out_red;
  logic [VAL_W-1:0] out_green;
  logic [VAL_W-1:0] out_blue;
  logic             cfg_wr_en;
  logic [IDX_W-1:0] cfg_index;
  logic [VAL_W-1:0] cfg_wdata;

  logic [VAL_W-1:0] sat_now;
  logic [VAL_W-1:0] light_now;
  rgb_t             rgb_due[$];
  int               err_cnt;
  bit               hold_request;

  hsl_to_rgb_converter_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_hue    (in_hue),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint hue_ramp(longint p, longint q, logic [HUE_W-1:0] t);
    longint d;
    d = q - p;
    if (t < FX_SIXTH) return p + (d * 6 * longint'(t)) / longint'(FX_ONE);
    if (t < FX_HUE_HALF) return q;
    if (t < FX_TWO_THIRDS)
      return p + (d * (longint'(FX_TWO_THIRDS) - longint'(t)) * 6) / longint'(FX_ONE);
    return p;
  endfunction

  function automatic logic [VAL_W-1:0] to_unit(longint v);
    if (v < 0) return '0;
    if (v > longint'(FX_ONE)) return FX_ONE;
    return v[VAL_W-1:0];
  endfunction

  function automatic rgb_t hsl_to_rgb(logic [HUE_W-1:0] hue, logic [VAL_W-1:0] sat_r,
                                      logic [VAL_W-1:0] light_r);
    longint s, l, q, p;
    logic [HUE_W-1:0] hue_r, hue_b;
    rgb_t c;
    s = (sat_r > FX_ONE) ? longint'(FX_ONE) : longint'(sat_r);
    l = (light_r > FX_ONE) ? longint'(FX_ONE) : longint'(light_r);
    if (s == 0) begin
      c.red   = to_unit(l);
      c.green = to_unit(l);
      c.blue  = to_unit(l);
    end else begin
      if (l < longint'(FX_HALF)) q = (l * (longint'(FX_ONE) + s)) / longint'(FX_ONE);
      else q = l + s - (l * s) / longint'(FX_ONE);
      p = 2 * l - q;
      hue_r = hue + FX_THIRD;
      hue_b = hue - FX_THIRD;
      c.red   = to_unit(hue_ramp(p, q, hue_r));
      c.green = to_unit(hue_ramp(p, q, hue));
      c.blue  = to_unit(hue_ramp(p, q, hue_b));
    end
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic logic [HUE_W-1:0] pick_hue();
    logic [HUE_W-1:0] edges [10];
    logic [HUE_W-1:0] h;
    edges = '{16'd0, 16'd10922, 16'd10923, 16'd21845, 16'd32767,
              16'd32768, 16'd43690, 16'd43691, 16'd54613, 16'd65535};
    if ($urandom_range(0, 99) < 25) begin
      h = edges[$urandom_range(0, 9)];
      h = h + HUE_W'($urandom_range(0, 6)) - 16'd3;
    end else begin
      h = HUE_W'($urandom_range(0, 65535));
    end
    return h;
  endfunction

  function automatic logic [VAL_W-1:0] pick_level();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return '0;
    if (r < 24) return FX_ONE;
    if (r < 34) return VAL_W'($urandom_range(65537, 131071));
    if (r < 42) return ($urandom_range(0, 1) != 0) ? 17'd32768 : 17'd32767;
    return VAL_W'($urandom_range(0, 65536));
  endfunction

  task automatic send_hue(logic [HUE_W-1:0] hue, rgb_t due, int gap);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_hue   = hue;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rgb_due.push_back(due);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (rgb_due.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic set_levels(logic [VAL_W-1:0] s, logic [VAL_W-1:0] l);
    drain();
    write_reg(REG_SATURATION, s);
    write_reg(REG_LIGHTNESS, l);
    sat_now   = s;
    light_now = l;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (rgb_due.size() == 0) begin
        $error("unexpected result transfer: red %0d green %0d blue %0d",
               out_red, out_green, out_blue);
        err_cnt++;
      end else begin
        rgb_t exp_c;
        exp_c = rgb_due.pop_front();
        if (out_red !== exp_c.red) begin
          $error("red: expected %0d, got %0d", exp_c.red, out_red);
          err_cnt++;
        end
        if (out_green !== exp_c.green) begin
          $error("green: expected %0d, got %0d", exp_c.green, out_green);
          err_cnt++;
        end
        if (out_blue !== exp_c.blue) begin
          $error("blue: expected %0d, got %0d", exp_c.blue, out_blue);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int r;
    int len;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall = 1'b1;
        len = HOLD_CYCLES;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_stall = 1'b0;
          len = $urandom_range(1, 6);
        end else if (r < 85) begin
          out_stall = 1'b1;
          len = $urandom_range(1, 3);
        end else if (r < 95) begin
          out_stall = 1'b0;
          len = $urandom_range(20, 60);
        end else begin
          out_stall = 1'b1;
          len = $urandom_range(10, 30);
        end
      end
      repeat (len - 1) @(negedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rgb_t due;
    logic [HUE_W-1:0] h;
    logic [VAL_W-1:0] s, l;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_hue       = '0;
    cfg_wr_en    = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    err_cnt      = 0;
    hold_request = 1'b0;
    sat_now      = SAT_RESET;
    light_now    = LIGHT_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_TAB[i].sat != sat_now || DIR_TAB[i].light != light_now)
        set_levels(DIR_TAB[i].sat, DIR_TAB[i].light);
      if (DIR_TAB[i].known) due = '{DIR_TAB[i].red, DIR_TAB[i].green, DIR_TAB[i].blue};
      else due = hsl_to_rgb(DIR_TAB[i].hue, sat_now, light_now);
      send_hue(DIR_TAB[i].hue, due, pick_gap());
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin s = '0;         l = pick_level(); end
        1: begin s = FX_ONE;     l = FX_ONE;       end
        2: begin s = FX_ONE;     l = '0;           end
        3: begin s = 17'd131071; l = 17'd40000;    end
        4: begin s = 17'd20000;  l = 17'd131071;   end
        default: begin s = pick_level(); l = pick_level(); end
      endcase
      set_levels(s, l);
      // long receiver hold-off while the sender keeps offering
      if (ph == 5) hold_request = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        h = pick_hue();
        send_hue(h, hsl_to_rgb(h, sat_now, light_now), pick_gap());
      end
    end

    drain();
    if (rgb_due.size() != 0) begin
      $error("%0d results never arrived", rgb_due.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
